>>> sv/ird_pkg.sv
`default_nettype none

package ird_pkg;

  // Operand width and derived sizes
  localparam int ValueWidth    = 32;
  localparam int InWidth       = 32;
  localparam int StepBits      = 8;
  localparam int StepsPerDigit = (ValueWidth + StepBits - 1) / StepBits;
  localparam int NumWidth      = StepsPerDigit * StepBits;
  localparam int StepCntWidth  = (StepsPerDigit > 1) ? $clog2(StepsPerDigit) : 1;
  localparam int CntWidth      = $clog2(ValueWidth + 1);
  localparam int IdxWidth      = $clog2(ValueWidth);

  // Digit and register widths
  localparam int DigitWidth = 4;
  localparam int BaseWidth  = 5;
  localparam int CharWidth  = 7;

  localparam logic [BaseWidth-1:0] BaseReset = BaseWidth'(10);
  localparam logic [BaseWidth-1:0] BaseMin   = BaseWidth'(2);
  localparam logic [BaseWidth-1:0] BaseMax   = BaseWidth'(16);

  localparam logic [CharWidth-1:0] AsciiDigitOffset  = CharWidth'(48);
  localparam logic [CharWidth-1:0] AsciiLetterOffset = CharWidth'(55);

  localparam logic [NumWidth-1:0] ValueMask = {NumWidth{1'b1}} >> (NumWidth - ValueWidth);

  // Controller states
  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StDivide = 3'b010,
    StEmit   = 3'b100
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic pop;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic digit_done;
    logic quot_zero;
    logic stack_full;
    logic last_one;
    logic out_free;
  } ctl_status_t;

  // Remainder value to upper-case ASCII
  function automatic logic [CharWidth-1:0] digit_to_ascii(input logic [DigitWidth-1:0] d);
    logic [CharWidth-1:0] ext;
    ext = CharWidth'(d);
    if (d <= DigitWidth'(9)) begin
      return ext + AsciiDigitOffset;
    end
    return ext + AsciiLetterOffset;
  endfunction

  // Clamp a written base into two to sixteen
  function automatic logic [BaseWidth-1:0] clamp_base(input logic [BaseWidth-1:0] b);
    if (b < BaseMin) begin
      return BaseMin;
    end
    if (b > BaseMax) begin
      return BaseMax;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

>>> sv/ird_datapath.sv
`default_nettype none

module ird_datapath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               dst_base_we_i,
  input  wire logic [ird_pkg::BaseWidth-1:0]      dst_base_i,
  input  wire logic [ird_pkg::InWidth-1:0]        value_i,
  input  wire ird_pkg::ctl_cmd_t                  cmd_i,
  output ird_pkg::ctl_status_t                    status_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [ird_pkg::CharWidth-1:0]           digit_char_o,
  output logic                                    last_digit_o
);

  logic [ird_pkg::BaseWidth-1:0]    base_q;
  logic [ird_pkg::NumWidth-1:0]     num_q, num_d;
  logic [ird_pkg::DigitWidth-1:0]   rem_q, rem_d;
  logic [ird_pkg::StepCntWidth-1:0] step_q;
  logic [ird_pkg::CntWidth-1:0]     cnt_q;
  logic [ird_pkg::DigitWidth-1:0]   stack_q [ird_pkg::ValueWidth];
  logic                             out_valid_q;
  logic [ird_pkg::CharWidth-1:0]    char_q;
  logic                             last_q;
  logic                             digit_done;
  logic [ird_pkg::IdxWidth-1:0]     pop_idx;

  // Base register, clamped on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= ird_pkg::BaseReset;
    end else if (dst_base_we_i) begin
      base_q <= ird_pkg::clamp_base(dst_base_i);
    end
  end

  // One radix-2 restoring step per dividend bit, StepBits bits per cycle
  always_comb begin
    logic [ird_pkg::NumWidth-1:0]   n;
    logic [ird_pkg::DigitWidth-1:0] r;
    logic [ird_pkg::BaseWidth-1:0]  r5;
    n = num_q;
    r = rem_q;
    for (int i = 0; i < ird_pkg::StepBits; i++) begin
      r5 = {r, n[ird_pkg::NumWidth-1]};
      n  = {n[ird_pkg::NumWidth-2:0], 1'b0};
      if (r5 >= base_q) begin
        r5   = r5 - base_q;
        n[0] = 1'b1;
      end
      r = r5[ird_pkg::DigitWidth-1:0];
    end
    num_d = n;
    rem_d = r;
  end

  assign digit_done = (step_q == ird_pkg::StepCntWidth'(ird_pkg::StepsPerDigit - 1));
  assign pop_idx    = ird_pkg::IdxWidth'(cnt_q - ird_pkg::CntWidth'(1));

  // Dividend, partial remainder and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.load) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= digit_done ? '0 : step_q + ird_pkg::StepCntWidth'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q <= ird_pkg::NumWidth'(value_i) & ird_pkg::ValueMask;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= num_d;
      rem_q <= digit_done ? '0 : rem_d;
    end
  end

  // Digit stack count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step && digit_done) begin
      cnt_q <= cnt_q + ird_pkg::CntWidth'(1);
    end else if (cmd_i.pop) begin
      cnt_q <= cnt_q - ird_pkg::CntWidth'(1);
    end
  end

  // Digit stack, least significant pushed first
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step && digit_done) begin
      stack_q[cnt_q[ird_pkg::IdxWidth-1:0]] <= rem_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.pop) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      char_q <= ird_pkg::digit_to_ascii(stack_q[pop_idx]);
      last_q <= (cnt_q == ird_pkg::CntWidth'(1));
    end
  end

  // Status
  assign status_o.digit_done = digit_done;
  assign status_o.quot_zero  = (num_d == '0);
  assign status_o.stack_full = (cnt_q == ird_pkg::CntWidth'(ird_pkg::ValueWidth - 1));
  assign status_o.last_one   = (cnt_q == ird_pkg::CntWidth'(1));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = char_q;
  assign last_digit_o = last_q;

endmodule

`default_nettype wire

>>> sv/ird_ctrl.sv
`default_nettype none

module ird_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire ird_pkg::ctl_status_t  status_i,
  output ird_pkg::ctl_cmd_t          cmd_o
);

  ird_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ird_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o.load       = 1'b0;
    cmd_o.div_step   = 1'b0;
    cmd_o.pop        = 1'b0;
    unique case (state_q)
      ird_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ird_pkg::StDivide;
        end
      end
      ird_pkg::StDivide: begin
        cmd_o.div_step = 1'b1;
        if (status_i.digit_done && (status_i.quot_zero || status_i.stack_full)) begin
          state_d = ird_pkg::StEmit;
        end
      end
      ird_pkg::StEmit: begin
        if (status_i.out_free) begin
          cmd_o.pop = 1'b1;
          if (status_i.last_one) begin
            state_d = ird_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = ird_pkg::StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/integer_to_radix_digits_core.sv
// Converts an unsigned integer into ASCII digits of a programmable radix.
// Input channel: value_i with in_valid_i / in_ready_o; a transfer takes one
// value. Output channel: digit_char_o and last_digit_o with out_valid_o /
// out_ready_i; one transfer per digit, most significant first, last_digit_o
// set on the least significant digit. Zero gives the single digit '0'.
// Radix: dst_base_i written on dst_base_we_i, clamped to 2..16, reset 10;
// write it only while no conversion is in flight.
// Sequence: one value at a time. After the input transfer, each digit is
// computed in the shared divider (8 quotient bits per cycle over a 32-bit
// dividend) and pushed on the digit stack; the digits are then popped
// from the digit stack into the output register. in_ready_o rises once
// the last digit is popped, so the next value overlaps the final output
// transfer.
// A stalled receiver holds the output register and pauses the stack pops.
// Reset clears the controller, the output valid and sets the radix to 10.
`default_nettype none

module integer_to_radix_digits_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          dst_base_we_i,
  input  wire logic [ird_pkg::BaseWidth-1:0] dst_base_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [ird_pkg::InWidth-1:0]   value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [ird_pkg::CharWidth-1:0]      digit_char_o,
  output logic                               last_digit_o
);

  ird_pkg::ctl_cmd_t    cmd;
  ird_pkg::ctl_status_t status;

  ird_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ird_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dst_base_we_i (dst_base_we_i),
    .dst_base_i    (dst_base_i),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digit_char_o  (digit_char_o),
    .last_digit_o  (last_digit_o)
  );

endmodule

`default_nettype wire
